// ===== sv/kcf_pkg.sv =====
package kcf_pkg;

    localparam int DEF_MAX_KEY_LEN = 32;
    localparam int DEF_COUNT_BITS  = 17;
    localparam int DEF_NUM_GUESSES = 5;

    localparam int RANK_FIELDS  = 5;
    localparam int BIN_BITS     = 8;
    localparam int KEY_LEN_BITS = 6;
    localparam int COL_OUT_BITS = 5;
    localparam int TOP_BITS     = 17;

    localparam logic [BIN_BITS-1:0] SPACE_CODE = 8'h20;
    localparam logic [BIN_BITS-1:0] ZERO_CHAR  = 8'h30;
    localparam logic [TOP_BITS-1:0] TOP_MAX    = 17'h1FFFF;

    typedef struct packed {
        logic clear;
        logic commit;
        logic sample;
        logic first;
    } sel_ctl_t;

endpackage

// ===== sv/kcf_ifs.sv =====
interface kcf_in_if;
    import kcf_pkg::*;

    logic                valid;
    logic                ready;
    logic [BIN_BITS-1:0] cipher_byte;
    logic                last_byte;

    modport source (output valid, output cipher_byte, output last_byte, input ready);
    modport sink (input valid, input cipher_byte, input last_byte, output ready);
endinterface

interface kcf_out_if;
    import kcf_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [COL_OUT_BITS-1:0] column;
    logic [BIN_BITS-1:0]     guess_first;
    logic [BIN_BITS-1:0]     guess_second;
    logic [BIN_BITS-1:0]     guess_third;
    logic [BIN_BITS-1:0]     guess_fourth;
    logic [BIN_BITS-1:0]     guess_fifth;
    logic [TOP_BITS-1:0]     top_count;
    logic                    last_column;

    modport source (
        output valid, output column, output guess_first, output guess_second,
        output guess_third, output guess_fourth, output guess_fifth,
        output top_count, output last_column, input ready
    );
    modport sink (
        input valid, input column, input guess_first, input guess_second,
        input guess_third, input guess_fourth, input guess_fifth,
        input top_count, input last_column, output ready
    );
endinterface

// ===== sv/kcf_ram.sv =====
module kcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== sv/kcf_select.sv =====
module kcf_select #(
    parameter int COUNT_BITS = kcf_pkg::DEF_COUNT_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  kcf_pkg::sel_ctl_t            ctl,
    input  logic [COUNT_BITS-1:0]        cnt,
    input  logic [kcf_pkg::BIN_BITS-1:0] bin,
    output logic [COUNT_BITS-1:0]        best_cnt,
    output logic [kcf_pkg::BIN_BITS-1:0] best_bin
);
    import kcf_pkg::*;

    logic                  found_reg;
    logic [COUNT_BITS-1:0] best_cnt_reg;
    logic [BIN_BITS-1:0]   best_bin_reg;
    logic [COUNT_BITS-1:0] prev_cnt_reg;
    logic [BIN_BITS-1:0]   prev_bin_reg;
    logic                  eligible;
    logic                  take;

    // order is count descending, then bin ascending; each pass takes the
    // largest key strictly below the one taken in the previous pass
    assign eligible = ctl.first || (cnt < prev_cnt_reg)
                      || ((cnt == prev_cnt_reg) && (bin > prev_bin_reg));
    assign take     = ctl.sample && eligible && (!found_reg || (cnt > best_cnt_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg    <= 1'b0;
            best_cnt_reg <= '0;
            best_bin_reg <= '0;
            prev_cnt_reg <= '0;
            prev_bin_reg <= '0;
        end
        else
        begin
            if (ctl.commit)
            begin
                prev_cnt_reg <= best_cnt_reg;
                prev_bin_reg <= best_bin_reg;
            end
            if (ctl.clear)
            begin
                found_reg <= 1'b0;
            end
            else if (take)
            begin
                found_reg    <= 1'b1;
                best_cnt_reg <= cnt;
                best_bin_reg <= bin;
            end
        end
    end

    assign best_cnt = best_cnt_reg;
    assign best_bin = best_bin_reg;
endmodule

// ===== sv/xor_key_column_frequency_guess.sv =====
// channel   | dir | handshake         | payload
// cipher    | in  | valid/ready       | cipher_byte, last_byte
// result    | out | valid/ready       | column, guess_first..guess_fifth, top_count, last_column
// key_length| in  | wr_en (no ready)  | key_length_wr_data
//
// Each byte is a counter read, then a saturating write back.
// On the last byte each column takes min(NUM_GUESSES,5) scans (S_SCAN over all 256 bins, then
// S_DRAIN and S_PICK) plus an emit step; the scans share one compare unit over the histogram RAM.
// After reset and after every message a clearing pass writes zero to all 2^AW counters
// (AW = max(clog2(MAX_KEY_LEN),1)+8, 8192 by default); cipher is not ready.
// A stalled result holds the emit step; the output register frees the scan path.
module xor_key_column_frequency_guess #(
    parameter int MAX_KEY_LEN = kcf_pkg::DEF_MAX_KEY_LEN,
    parameter int COUNT_BITS  = kcf_pkg::DEF_COUNT_BITS,
    parameter int NUM_GUESSES = kcf_pkg::DEF_NUM_GUESSES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             key_length_wr_en,
    input  logic [kcf_pkg::KEY_LEN_BITS-1:0] key_length_wr_data,
    kcf_in_if.sink                           cipher,
    kcf_out_if.source                        result
);
    import kcf_pkg::*;

    localparam int CW     = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
    localparam int AW     = CW + BIN_BITS;
    localparam int PASSES = (NUM_GUESSES < RANK_FIELDS) ? NUM_GUESSES : RANK_FIELDS;
    localparam int TW     = (COUNT_BITS > TOP_BITS) ? COUNT_BITS : TOP_BITS;
    localparam logic [KEY_LEN_BITS:0] MaxLen = (KEY_LEN_BITS+1)'(MAX_KEY_LEN);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_UPD,
        S_SCAN,
        S_DRAIN,
        S_PICK,
        S_EMIT
    } state_t;

    state_t                  state_reg, state_next;
    logic [KEY_LEN_BITS-1:0] key_len_reg;
    logic [KEY_LEN_BITS-1:0] col_ptr_reg, col_ptr_next;
    logic                    last_reg, last_next;
    logic [AW-1:0]           clr_addr_reg, clr_addr_next;
    logic [BIN_BITS-1:0]     bin_reg, bin_next;
    logic                    rd_pend_reg, rd_pend_next;
    logic [2:0]              rank_reg, rank_next;
    logic [KEY_LEN_BITS-1:0] rcol_reg, rcol_next;
    logic                    res_valid_reg, res_valid_next;

    logic [AW-1:0]           upd_addr_reg;
    logic [BIN_BITS-1:0]     bin_d_reg;
    logic [BIN_BITS-1:0]     guess_reg [RANK_FIELDS];
    logic [COUNT_BITS-1:0]   top_reg;
    logic [COL_OUT_BITS-1:0] out_col_reg;
    logic [BIN_BITS-1:0]     out_guess_reg [RANK_FIELDS];
    logic [TOP_BITS-1:0]     out_top_reg;
    logic                    out_last_reg;

    logic [KEY_LEN_BITS-1:0] eff_len;
    logic [KEY_LEN_BITS-1:0] cur_col;
    logic [KEY_LEN_BITS-1:0] col_inc;
    logic [BIN_BITS-1:0]     guess;
    logic                    load_out;
    logic                    pick;
    logic                    final_col;
    sel_ctl_t                sel_ctl;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [COUNT_BITS-1:0]   ram_wdata;
    logic [AW-1:0]           ram_raddr;
    logic [COUNT_BITS-1:0]   ram_rdata;
    logic [COUNT_BITS-1:0]   best_cnt;
    logic [BIN_BITS-1:0]     best_bin;
    logic [TW-1:0]           top_wide;
    logic [TOP_BITS-1:0]     top_sat;

    always_comb
    begin
        if (key_len_reg == '0)
        begin
            eff_len = KEY_LEN_BITS'(1);
        end
        else if ({1'b0, key_len_reg} > MaxLen)
        begin
            eff_len = MaxLen[KEY_LEN_BITS-1:0];
        end
        else
        begin
            eff_len = key_len_reg;
        end
    end

    assign cur_col   = (col_ptr_reg >= eff_len) ? '0 : col_ptr_reg;
    assign col_inc   = cur_col + KEY_LEN_BITS'(1);
    assign guess     = ((cipher.cipher_byte ^ SPACE_CODE) == '0) ? ZERO_CHAR
                       : (cipher.cipher_byte ^ SPACE_CODE);
    assign final_col = (rcol_reg == (eff_len - KEY_LEN_BITS'(1)));

    always_comb
    begin
        state_next     = state_reg;
        col_ptr_next   = col_ptr_reg;
        last_next      = last_reg;
        clr_addr_next  = clr_addr_reg;
        bin_next       = bin_reg;
        rd_pend_next   = 1'b0;
        rank_next      = rank_reg;
        rcol_next      = rcol_reg;
        res_valid_next = res_valid_reg && !result.ready;
        load_out       = 1'b0;
        pick           = 1'b0;
        sel_ctl        = '0;
        sel_ctl.sample = rd_pend_reg;
        sel_ctl.first  = (rank_reg == '0);

        unique case (state_reg)
            S_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == '1)
                begin
                    col_ptr_next = '0;
                    state_next   = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cipher.valid)
                begin
                    col_ptr_next = (col_inc >= eff_len) ? '0 : col_inc;
                    last_next    = cipher.last_byte;
                    state_next   = S_UPD;
                end
            end
            S_UPD:
            begin
                sel_ctl.clear = 1'b1;
                if (last_reg)
                begin
                    rcol_next  = '0;
                    rank_next  = '0;
                    bin_next   = '0;
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                rd_pend_next = 1'b1;
                bin_next     = bin_reg + BIN_BITS'(1);
                if (bin_reg == '1)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_PICK;
            end
            S_PICK:
            begin
                sel_ctl.clear  = 1'b1;
                sel_ctl.commit = 1'b1;
                pick           = 1'b1;
                if (rank_reg == 3'(PASSES - 1))
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    rank_next  = rank_reg + 3'd1;
                    state_next = S_SCAN;
                end
            end
            S_EMIT:
            begin
                if (!res_valid_reg || result.ready)
                begin
                    load_out       = 1'b1;
                    res_valid_next = 1'b1;
                    rank_next      = '0;
                    if (final_col)
                    begin
                        clr_addr_next = '0;
                        state_next    = S_CLEAR;
                    end
                    else
                    begin
                        rcol_next  = rcol_reg + KEY_LEN_BITS'(1);
                        state_next = S_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            key_len_reg   <= KEY_LEN_BITS'(1);
            col_ptr_reg   <= '0;
            last_reg      <= 1'b0;
            clr_addr_reg  <= '0;
            bin_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            rank_reg      <= '0;
            rcol_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_ptr_reg   <= col_ptr_next;
            last_reg      <= last_next;
            clr_addr_reg  <= clr_addr_next;
            bin_reg       <= bin_next;
            rd_pend_reg   <= rd_pend_next;
            rank_reg      <= rank_next;
            rcol_reg      <= rcol_next;
            res_valid_reg <= res_valid_next;
            if (key_length_wr_en)
            begin
                key_len_reg <= key_length_wr_data;
            end
        end
    end

    assign top_wide = TW'(top_reg);
    assign top_sat  = (top_wide > TW'(TOP_MAX)) ? TOP_MAX : top_wide[TOP_BITS-1:0];

    always_ff @(posedge clk)
    begin
        bin_d_reg <= bin_reg;
        if ((state_reg == S_IDLE) && cipher.valid)
        begin
            upd_addr_reg <= {cur_col[CW-1:0], guess};
        end
        if (pick)
        begin
            guess_reg[rank_reg] <= best_bin;
            if (rank_reg == '0)
            begin
                top_reg <= best_cnt;
            end
        end
        if (load_out)
        begin
            out_col_reg  <= COL_OUT_BITS'(rcol_reg);
            out_top_reg  <= top_sat;
            out_last_reg <= final_col;
            for (int i = 0; i < RANK_FIELDS; i++)
            begin
                out_guess_reg[i] <= (i < PASSES) ? guess_reg[i] : '0;
            end
        end
    end

    // memory port steering
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = clr_addr_reg;
        ram_wdata = '0;
        ram_raddr = {rcol_reg[CW-1:0], bin_reg};
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we = 1'b1;
            end
            S_IDLE:
            begin
                ram_raddr = {cur_col[CW-1:0], guess};
            end
            S_UPD:
            begin
                ram_we    = 1'b1;
                ram_waddr = upd_addr_reg;
                ram_wdata = (ram_rdata == '1) ? ram_rdata : ram_rdata + COUNT_BITS'(1);
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    kcf_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (2 ** AW)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    kcf_select #(
        .COUNT_BITS (COUNT_BITS)
    ) u_select (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (sel_ctl),
        .cnt      (ram_rdata),
        .bin      (bin_d_reg),
        .best_cnt (best_cnt),
        .best_bin (best_bin)
    );

    assign cipher.ready        = (state_reg == S_IDLE);
    assign result.valid        = res_valid_reg;
    assign result.column       = out_col_reg;
    assign result.guess_first  = out_guess_reg[0];
    assign result.guess_second = out_guess_reg[1];
    assign result.guess_third  = out_guess_reg[2];
    assign result.guess_fourth = out_guess_reg[3];
    assign result.guess_fifth  = out_guess_reg[4];
    assign result.top_count    = out_top_reg;
    assign result.last_column  = out_last_reg;
endmodule

// ===== tb/kcf_guess_check.sv =====
module kcf_guess_check (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             key_length_wr_en,
    input  logic [kcf_pkg::KEY_LEN_BITS-1:0] key_length_wr_data,
    kcf_in_if                                cipher,
    kcf_out_if                               result,
    output int                               mismatches,
    output int                               awaited
);
    import kcf_pkg::*;

    localparam int COLS = DEF_MAX_KEY_LEN;
    localparam int BINS = 1 << BIN_BITS;

    typedef struct packed {
        logic [COL_OUT_BITS-1:0] column;
        logic [BIN_BITS-1:0]     guess_first;
        logic [BIN_BITS-1:0]     guess_second;
        logic [BIN_BITS-1:0]     guess_third;
        logic [BIN_BITS-1:0]     guess_fourth;
        logic [BIN_BITS-1:0]     guess_fifth;
        logic [TOP_BITS-1:0]     top_count;
        logic                    last_column;
    } column_rank_t;

    logic [DEF_COUNT_BITS-1:0] guess_tally [COLS][BINS];
    int                        next_col;
    logic [KEY_LEN_BITS-1:0]   key_len;
    column_rank_t              ranked_columns [$];

    function automatic int column_span(logic [KEY_LEN_BITS-1:0] kl);
        if (kl == 0)
            return 1;
        if (int'(kl) > COLS)
            return COLS;
        return int'(kl);
    endfunction

    // Repeated max scan; strict compare keeps the lower byte on ties.
    function automatic column_rank_t rank_column(int c, logic closing);
        logic                      taken [BINS];
        logic [BIN_BITS-1:0]       pick [RANK_FIELDS];
        logic [DEF_COUNT_BITS-1:0] best_cnt;
        logic [DEF_COUNT_BITS-1:0] top;
        int                        best;
        column_rank_t              row;
        taken = '{default: 1'b0};
        top = '0;
        for (int r = 0; r < RANK_FIELDS; r++)
        begin
            best = -1;
            best_cnt = '0;
            for (int v = 0; v < BINS; v++)
            begin
                if (!taken[v] && (best < 0 || guess_tally[c][v] > best_cnt))
                begin
                    best = v;
                    best_cnt = guess_tally[c][v];
                end
            end
            taken[best] = 1'b1;
            if (r == 0)
                top = best_cnt;
            pick[r] = (r < DEF_NUM_GUESSES) ? 8'(best) : 8'd0;
        end
        row.column       = COL_OUT_BITS'(c);
        row.guess_first  = pick[0];
        row.guess_second = pick[1];
        row.guess_third  = pick[2];
        row.guess_fourth = pick[3];
        row.guess_fifth  = pick[4];
        row.top_count    = (top > TOP_MAX) ? TOP_MAX : TOP_BITS'(top);
        row.last_column  = closing;
        return row;
    endfunction

    task automatic match_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        int                  span;
        int                  col;
        logic [BIN_BITS-1:0] guess;
        column_rank_t        want;
        if (!rst_n)
        begin
            for (int c = 0; c < COLS; c++)
                for (int v = 0; v < BINS; v++)
                    guess_tally[c][v] = '0;
            next_col = 0;
            key_len = KEY_LEN_BITS'(1);
            ranked_columns.delete();
            mismatches = 0;
            awaited = 0;
        end
        else
        begin
            if (key_length_wr_en)
                key_len = key_length_wr_data;

            if (cipher.valid && cipher.ready)
            begin
                span = column_span(key_len);
                if (next_col >= span)
                    next_col = 0;
                col = next_col;
                guess = cipher.cipher_byte ^ SPACE_CODE;
                if (guess == 0)
                    guess = ZERO_CHAR;
                if (guess_tally[col][guess] != '1)
                    guess_tally[col][guess] = guess_tally[col][guess] + 1'b1;
                next_col = (col + 1 >= span) ? 0 : col + 1;
                if (cipher.last_byte)
                begin
                    for (int c = 0; c < span; c++)
                        ranked_columns.push_back(rank_column(c, c + 1 == span));
                    for (int c = 0; c < COLS; c++)
                        for (int v = 0; v < BINS; v++)
                            guess_tally[c][v] = '0;
                    next_col = 0;
                end
            end

            if (result.valid && result.ready)
            begin
                if (ranked_columns.size() == 0)
                begin
                    $error("result transaction for column %0d with none expected",
                           result.column);
                    mismatches++;
                end
                else
                begin
                    want = ranked_columns.pop_front();
                    match_field("column", 32'(want.column), 32'(result.column));
                    match_field("guess_first", 32'(want.guess_first),
                                32'(result.guess_first));
                    match_field("guess_second", 32'(want.guess_second),
                                32'(result.guess_second));
                    match_field("guess_third", 32'(want.guess_third),
                                32'(result.guess_third));
                    match_field("guess_fourth", 32'(want.guess_fourth),
                                32'(result.guess_fourth));
                    match_field("guess_fifth", 32'(want.guess_fifth),
                                32'(result.guess_fifth));
                    match_field("top_count", 32'(want.top_count), 32'(result.top_count));
                    match_field("last_column", 32'(want.last_column),
                                32'(result.last_column));
                end
            end
            awaited = ranked_columns.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
module testbench;
    import kcf_pkg::*;

    localparam int CLEAR_GAP      = (1 << ($clog2(DEF_MAX_KEY_LEN) + BIN_BITS)) + 64;
    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 42;
    localparam int PRESSURE_PHASE = 4;
    localparam int PRESSURE_LEN   = 12;
    localparam int HOLD_CYCLES    = 20000;
    localparam logic [KEY_LEN_BITS-1:0] PHASE_KEY [PHASES] =
        '{6'd1, 6'd32, 6'd3, 6'd6, 6'd0, 6'd2, 6'd63, 6'd5, 6'd4, 6'd9};

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    key_length_wr_en = 1'b0;
    logic [KEY_LEN_BITS-1:0] key_length_wr_data = '0;

    int mismatches;
    int awaited;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int long_hold = 0;
    int tb_span = 1;
    logic [BIN_BITS-1:0] cipher_key [DEF_MAX_KEY_LEN];

    kcf_in_if  cipher_ch ();
    kcf_out_if result_ch ();

    xor_key_column_frequency_guess uut (
        .clk                (clk),
        .rst_n              (rst_n),
        .key_length_wr_en   (key_length_wr_en),
        .key_length_wr_data (key_length_wr_data),
        .cipher             (cipher_ch),
        .result             (result_ch)
    );

    kcf_guess_check guess_check (
        .clk                (clk),
        .rst_n              (rst_n),
        .key_length_wr_en   (key_length_wr_en),
        .key_length_wr_data (key_length_wr_data),
        .cipher             (cipher_ch),
        .result             (result_ch),
        .mismatches         (mismatches),
        .awaited            (awaited)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #300_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        int hold_left;
        hold_left = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold != 0)
            begin
                hold_left = long_hold;
                long_hold = 0;
            end
            if (hold_left > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Leaves valid high after the transaction; callers lower it via drain.
    task automatic send_byte(input logic [BIN_BITS-1:0] b, input logic lst);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cipher_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cipher_ch.valid       <= 1'b1;
        cipher_ch.cipher_byte <= b;
        cipher_ch.last_byte   <= lst;
        do
            @(posedge clk);
        while (!cipher_ch.ready);
        @(negedge clk);
    endtask

    task automatic drain();
        cipher_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (awaited != 0);
    endtask

    task automatic settle();
        drain();
        repeat (CLEAR_GAP) @(negedge clk);
    endtask

    task automatic set_key_length(input logic [KEY_LEN_BITS-1:0] v);
        settle();
        key_length_wr_en   <= 1'b1;
        key_length_wr_data <= v;
        @(negedge clk);
        key_length_wr_en <= 1'b0;
        tb_span = (v == 0) ? 1 : ((int'(v) > DEF_MAX_KEY_LEN) ? DEF_MAX_KEY_LEN : int'(v));
    endtask

    // Text-like messages (mostly spaces under a random repeating key) or noisy random bytes.
    task automatic send_message(input int n, input bit noisy, input bit closed);
        logic [BIN_BITS-1:0] plain;
        logic [BIN_BITS-1:0] b;
        int                  col;
        int                  roll;
        col = 0;
        foreach (cipher_key[k])
            cipher_key[k] = 8'($urandom);
        for (int i = 0; i < n; i++)
        begin
            if (noisy)
                b = 8'($urandom);
            else
            begin
                roll = $urandom_range(99);
                if (roll < 60)
                    plain = SPACE_CODE;
                else if (roll < 90)
                    plain = 8'($urandom_range(8'h7a, 8'h61));
                else
                    plain = 8'($urandom);
                b = plain ^ cipher_key[col];
                col = (col + 1 >= tb_span) ? 0 : col + 1;
            end
            send_byte(b, closed && (i == n - 1));
        end
    endtask

    initial
    begin
        int n;
        int sent;
        int msgs;
        bit broken;
        bit closing;
        cipher_ch.valid       = 1'b0;
        cipher_ch.cipher_byte = '0;
        cipher_ch.last_byte   = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // zero key length, byte extremes, space byte folding onto '0'
        set_key_length(6'd0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(SPACE_CODE, 1'b0);
        send_byte(8'h10, 1'b0);
        send_byte(SPACE_CODE, 1'b1);

        // oversized key length, mostly empty columns
        set_key_length(6'd63);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h7F, 1'b1);

        // shrink key length with the column pointer past the new length
        set_key_length(6'd5);
        repeat (7) send_byte(8'($urandom), 1'b0);
        set_key_length(6'd2);
        send_byte(8'h41, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b1);

        for (int p = 0; p < PHASES; p++)
        begin
            set_key_length(PHASE_KEY[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            sent = 0;
            msgs = 0;
            broken = 1'($urandom_range(1));
            while (sent < PHASE_ITEMS)
            begin
                if ($urandom_range(9) == 0)
                    n = $urandom_range(3, 1);
                else
                    n = $urandom_range((tb_span > 12) ? 48 : 24, 4);
                // short messages keep several closed ones queued behind the hold
                if (p == PRESSURE_PHASE && n > PRESSURE_LEN)
                    n = PRESSURE_LEN;
                if (n > PHASE_ITEMS - sent)
                    n = PHASE_ITEMS - sent;
                closing = (sent + n < PHASE_ITEMS) || !broken;
                send_message(n, $urandom_range(3) == 0, closing);
                sent += n;
                msgs++;
                if (p == PRESSURE_PHASE && msgs == 1)
                    long_hold = HOLD_CYCLES;
                if (p % 4 == 3 && $urandom_range(3) == 0)
                    drain();
            end
        end

        settle();
        if (mismatches == 0 && awaited == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/kcf_pkg.sv
sv/kcf_ifs.sv
sv/kcf_ram.sv
sv/kcf_select.sv
sv/xor_key_column_frequency_guess.sv
tb/kcf_guess_check.sv
tb/testbench.sv
